// ----- rtl/tcr_pkg.sv -----
package tcr_pkg;

  localparam int VEL_W  = 17;
  localparam int EXT_W  = 16;
  localparam int FLAG_W = 20;
  localparam int TILE_W = 11;
  localparam int ATTR_W = 8;

  localparam int TILE_SHIFT  = 13;
  localparam int HALF_TILE   = 'h1000;
  localparam int BLOCK_REACH = 'hA00;
  localparam int WATER_REACH = 'hC00;
  localparam int SLOPE_OFS   = 'h800;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TILE  = 1'b1;

  localparam logic [ATTR_W-1:0] ATTR_WATER_A = 8'h02;
  localparam logic [ATTR_W-1:0] ATTR_BLOCK_A = 8'h03;
  localparam logic [ATTR_W-1:0] ATTR_BW_A    = 8'h04;
  localparam logic [ATTR_W-1:0] ATTR_BLOCK_B = 8'h05;
  localparam logic [ATTR_W-1:0] ATTR_BLOCK_C = 8'h41;
  localparam logic [ATTR_W-1:0] ATTR_BLOCK_D = 8'h43;
  localparam logic [ATTR_W-1:0] ATTR_NPC_BLK = 8'h44;
  localparam logic [ATTR_W-1:0] ATTR_WATER_B = 8'h60;
  localparam logic [ATTR_W-1:0] ATTR_BW_B    = 8'h61;
  localparam logic [ATTR_W-1:0] ATTR_WATER_C = 8'h62;
  localparam logic [ATTR_W-1:0] ATTR_BW_C    = 8'h64;

  localparam logic [4:0] ATTR_SLOPE_GRP  = 5'h0A;
  localparam logic [4:0] ATTR_SLOPEW_GRP = 5'h0E;
  localparam logic [5:0] ATTR_CUR_GRP    = 6'h20;
  localparam logic [5:0] ATTR_CURW_GRP   = 6'h28;

  localparam logic [FLAG_W-1:0] FLG_LEFT     = 20'h00001;
  localparam logic [FLAG_W-1:0] FLG_CEIL     = 20'h00002;
  localparam logic [FLAG_W-1:0] FLG_RIGHT    = 20'h00004;
  localparam logic [FLAG_W-1:0] FLG_FLOOR    = 20'h00008;
  localparam logic [FLAG_W-1:0] FLG_SLOPE_GH = 20'h00018;
  localparam logic [FLAG_W-1:0] FLG_SLOPE_EF = 20'h00028;
  localparam logic [FLAG_W-1:0] FLG_WATER    = 20'h00100;
  localparam logic [FLAG_W-1:0] FLG_CURRENT  = 20'h01000;
  localparam logic [FLAG_W-1:0] FLG_KIND_E   = 20'h10000;

  typedef struct packed {
    logic [EXT_W-1:0] half_width;
    logic [EXT_W-1:0] top;
    logic [EXT_W-1:0] bottom;
    logic             ignore_npc;
  } box_t;

  typedef struct packed {
    logic       block;
    logic       slope;
    logic       water;
    logic       current;
    logic       water_flag;
  } act_t;

  // slopes A, B, G and H descend with x
  function automatic logic slope_dir_neg(input logic [2:0] k);
    logic r;
    unique case (k)
      3'd0, 3'd1, 3'd6, 3'd7: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic slope_ofs_neg(input logic [2:0] k);
    logic r;
    unique case (k)
      3'd1, 3'd2, 3'd4, 3'd7: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/tcr_in_if.sv -----
interface tcr_in_if #(
  parameter int POS_WIDTH = 25
);
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic signed [POS_WIDTH-1:0]      pos_x;
  logic signed [POS_WIDTH-1:0]      pos_y;
  logic signed [tcr_pkg::VEL_W-1:0] vel_y;
  logic [tcr_pkg::EXT_W-1:0]        half_width;
  logic [tcr_pkg::EXT_W-1:0]        extent_top;
  logic [tcr_pkg::EXT_W-1:0]        extent_bottom;
  logic                             skip_npc_block;
  logic signed [tcr_pkg::TILE_W-1:0] tile_col;
  logic signed [tcr_pkg::TILE_W-1:0] tile_row;
  logic [tcr_pkg::ATTR_W-1:0]       tile_attr;

  modport source (
    output valid, kind, pos_x, pos_y, vel_y, half_width, extent_top, extent_bottom,
           skip_npc_block, tile_col, tile_row, tile_attr,
    input  ready
  );
  modport sink (
    input  valid, kind, pos_x, pos_y, vel_y, half_width, extent_top, extent_bottom,
           skip_npc_block, tile_col, tile_row, tile_attr,
    output ready
  );
endinterface

// ----- rtl/tcr_out_if.sv -----
interface tcr_out_if #(
  parameter int POS_WIDTH = 25
);
  logic                              valid;
  logic                              ready;
  logic signed [POS_WIDTH-1:0]       new_x;
  logic signed [POS_WIDTH-1:0]       new_y;
  logic signed [tcr_pkg::VEL_W-1:0]  new_vel_y;
  logic [tcr_pkg::FLAG_W-1:0]        hit_flags;

  modport source (
    output valid, new_x, new_y, new_vel_y, hit_flags,
    input  ready
  );
  modport sink (
    input  valid, new_x, new_y, new_vel_y, hit_flags,
    output ready
  );
endinterface

// ----- rtl/tcr_core.sv -----
module tcr_core #(
  parameter int POS_WIDTH = 25
) (
  input  logic                              kind,
  input  logic signed [POS_WIDTH-1:0]       pos_x,
  input  logic signed [POS_WIDTH-1:0]       pos_y,
  input  logic signed [tcr_pkg::VEL_W-1:0]  vel_y,
  input  tcr_pkg::box_t                     box_in,
  input  logic signed [tcr_pkg::TILE_W-1:0] tile_col,
  input  logic signed [tcr_pkg::TILE_W-1:0] tile_row,
  input  logic [tcr_pkg::ATTR_W-1:0]        tile_attr,
  input  logic signed [POS_WIDTH-1:0]       cur_x,
  input  logic signed [POS_WIDTH-1:0]       cur_y,
  input  logic signed [tcr_pkg::VEL_W-1:0]  cur_vel,
  input  logic [tcr_pkg::FLAG_W-1:0]        cur_flags,
  input  tcr_pkg::box_t                     cur_box,
  output logic signed [POS_WIDTH-1:0]       nxt_x,
  output logic signed [POS_WIDTH-1:0]       nxt_y,
  output logic signed [tcr_pkg::VEL_W-1:0]  nxt_vel,
  output logic [tcr_pkg::FLAG_W-1:0]        nxt_flags,
  output tcr_pkg::box_t                     nxt_box
);

  localparam int TXW  = tcr_pkg::TILE_W + tcr_pkg::TILE_SHIFT;
  localparam int MAXW = (POS_WIDTH > TXW) ? POS_WIDTH : TXW;
  localparam int CW   = MAXW + 4;

  localparam logic signed [CW-1:0] HT = CW'(tcr_pkg::HALF_TILE);
  localparam logic signed [CW-1:0] BR = CW'(tcr_pkg::BLOCK_REACH);
  localparam logic signed [CW-1:0] WR = CW'(tcr_pkg::WATER_REACH);
  localparam logic signed [CW-1:0] SO = CW'(tcr_pkg::SLOPE_OFS);

  function automatic logic signed [CW-1:0] wrapc(input logic signed [CW-1:0] v);
    logic signed [POS_WIDTH-1:0] t;
    t = signed'(v[POS_WIDTH-1:0]);
    return CW'(t);
  endfunction

  tcr_pkg::act_t act;
  logic signed [CW-1:0] tx, ty, hw, tp, bt;

  assign tx = signed'({{(CW-TXW){tile_col[tcr_pkg::TILE_W-1]}}, tile_col,
                       {tcr_pkg::TILE_SHIFT{1'b0}}});
  assign ty = signed'({{(CW-TXW){tile_row[tcr_pkg::TILE_W-1]}}, tile_row,
                       {tcr_pkg::TILE_SHIFT{1'b0}}});
  assign hw = signed'({{(CW-tcr_pkg::EXT_W){1'b0}}, cur_box.half_width});
  assign tp = signed'({{(CW-tcr_pkg::EXT_W){1'b0}}, cur_box.top});
  assign bt = signed'({{(CW-tcr_pkg::EXT_W){1'b0}}, cur_box.bottom});

  always_comb begin
    act = '0;
    priority if (tile_attr[7:3] == tcr_pkg::ATTR_SLOPE_GRP) begin
      act.slope = 1'b1;
    end else if (tile_attr[7:3] == tcr_pkg::ATTR_SLOPEW_GRP) begin
      act.slope = 1'b1;
      act.water = 1'b1;
    end else if (tile_attr[7:2] == tcr_pkg::ATTR_CUR_GRP) begin
      act.current = 1'b1;
    end else if (tile_attr[7:2] == tcr_pkg::ATTR_CURW_GRP) begin
      act.current    = 1'b1;
      act.water_flag = 1'b1;
    end else if (tile_attr == tcr_pkg::ATTR_NPC_BLK) begin
      act.block = !cur_box.ignore_npc;
    end else if (tile_attr == tcr_pkg::ATTR_BLOCK_A || tile_attr == tcr_pkg::ATTR_BLOCK_B ||
                 tile_attr == tcr_pkg::ATTR_BLOCK_C || tile_attr == tcr_pkg::ATTR_BLOCK_D) begin
      act.block = 1'b1;
    end else if (tile_attr == tcr_pkg::ATTR_WATER_A || tile_attr == tcr_pkg::ATTR_WATER_B ||
                 tile_attr == tcr_pkg::ATTR_WATER_C) begin
      act.water = 1'b1;
    end else if (tile_attr == tcr_pkg::ATTR_BW_A || tile_attr == tcr_pkg::ATTR_BW_B ||
                 tile_attr == tcr_pkg::ATTR_BW_C) begin
      act.block = 1'b1;
      act.water = 1'b1;
    end else begin
      act = '0;
    end
  end

  always_comb begin
    logic signed [CW-1:0]             xa, ya, d, rnd, ds, half, line;
    logic signed [tcr_pkg::VEL_W-1:0] va;
    logic [tcr_pkg::FLAG_W-1:0]       fl;
    logic [2:0]                       k;
    logic                             ybox, xbox, in_x, lo_ok;

    xa   = CW'(cur_x);
    ya   = CW'(cur_y);
    va   = cur_vel;
    fl   = cur_flags;
    k    = tile_attr[2:0];
    ybox = 1'b0;
    xbox = 1'b0;

    // block push-out: left, right, ceiling, floor in turn
    if (act.block) begin
      ybox = (ya - tp < ty + BR) && (ya + bt > ty - BR);
      if (ybox && (xa - hw < tx + HT) && (xa - hw > tx)) begin
        xa = wrapc(tx + HT + hw);
        fl = fl | tcr_pkg::FLG_LEFT;
      end
      if (ybox && (xa + hw > tx - HT) && (xa + hw < tx)) begin
        xa = wrapc(tx - HT - hw);
        fl = fl | tcr_pkg::FLG_RIGHT;
      end
      xbox = (xa - hw < tx + BR) && (xa + hw > tx - BR);
      if (xbox && (ya - tp < ty + HT) && (ya - tp > ty)) begin
        ya = wrapc(ty + HT + tp);
        va = '0;
        fl = fl | tcr_pkg::FLG_CEIL;
      end
      if (xbox && (ya + bt > ty - HT) && (ya + bt < ty)) begin
        ya = wrapc(ty - HT - bt);
        va = '0;
        fl = fl | tcr_pkg::FLG_FLOOR;
      end
    end

    // halve toward zero
    d    = xa - tx;
    rnd  = signed'({{(CW-1){1'b0}}, d[CW-1]});
    ds   = d + rnd;
    half = ds >>> 1;
    line = ty + (tcr_pkg::slope_dir_neg(k) ? -half : half)
              + (tcr_pkg::slope_ofs_neg(k) ? -SO : SO);
    lo_ok = (k == 3'd5) ? (xa >= tx - HT) : (xa > tx - HT);
    in_x  = (xa < tx + HT) && lo_ok;

    if (act.slope) begin
      if (!k[2]) begin
        if (in_x && (ya - tp < line) && (ya + bt > ty - HT)) begin
          ya = wrapc(line + tp);
          if (va[tcr_pkg::VEL_W-1]) begin
            va = '0;
          end
          fl = fl | tcr_pkg::FLG_CEIL;
        end
      end else begin
        fl = fl | (tcr_pkg::FLG_KIND_E << k[1:0]);
        if (in_x && (ya + bt > line) && (ya - tp < ty + HT)) begin
          ya = wrapc(line - bt);
          if (!va[tcr_pkg::VEL_W-1] && (va != '0)) begin
            va = '0;
          end
          fl = fl | (k[1] ? tcr_pkg::FLG_SLOPE_GH : tcr_pkg::FLG_SLOPE_EF);
        end
      end
    end

    if (act.water && (xa - hw < tx + WR) && (xa + hw > tx - WR) &&
        (ya - tp < ty + WR) && (ya + bt > ty - WR)) begin
      fl = fl | tcr_pkg::FLG_WATER;
    end
    if (act.water_flag) begin
      fl = fl | tcr_pkg::FLG_WATER;
    end
    if (act.current) begin
      fl = fl | (tcr_pkg::FLG_CURRENT << tile_attr[1:0]);
    end

    if (kind == tcr_pkg::KIND_START) begin
      nxt_x     = pos_x;
      nxt_y     = pos_y;
      nxt_vel   = vel_y;
      nxt_flags = '0;
      nxt_box   = box_in;
    end else begin
      nxt_x     = xa[POS_WIDTH-1:0];
      nxt_y     = ya[POS_WIDTH-1:0];
      nxt_vel   = va;
      nxt_flags = fl;
      nxt_box   = cur_box;
    end
  end

endmodule

// ----- rtl/tile_collision_resolver.sv -----
// Latency: a result is valid in the cycle after its input transfer.
// Throughput: one item per cycle while the output is not stalled; the next-state
// logic from the object state registers back to themselves is combinational.
// An output register lets a new item be taken while the last result is taken.
// Reset (rst_n low, synchronous): object state, flags and output valid clear.
module tile_collision_resolver #(
  parameter int POS_WIDTH = 25
) (
  input  logic      clk,
  input  logic      rst_n,
  tcr_in_if.sink    in_ch,
  tcr_out_if.source out_ch
);

  logic signed [POS_WIDTH-1:0]      cur_x_r, cur_y_r;
  logic signed [tcr_pkg::VEL_W-1:0] cur_vel_r;
  logic [tcr_pkg::FLAG_W-1:0]       flags_r;
  tcr_pkg::box_t                    box_r;

  logic signed [POS_WIDTH-1:0]      x_nxt, y_nxt;
  logic signed [tcr_pkg::VEL_W-1:0] vel_nxt;
  logic [tcr_pkg::FLAG_W-1:0]       flags_nxt;
  tcr_pkg::box_t                    box_nxt, box_in;

  logic out_valid_r;
  logic accept;

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign box_in.half_width = in_ch.half_width;
  assign box_in.top        = in_ch.extent_top;
  assign box_in.bottom     = in_ch.extent_bottom;
  assign box_in.ignore_npc = in_ch.skip_npc_block;

  tcr_core #(.POS_WIDTH(POS_WIDTH)) u_core (
    .kind      (in_ch.kind),
    .pos_x     (in_ch.pos_x),
    .pos_y     (in_ch.pos_y),
    .vel_y     (in_ch.vel_y),
    .box_in    (box_in),
    .tile_col  (in_ch.tile_col),
    .tile_row  (in_ch.tile_row),
    .tile_attr (in_ch.tile_attr),
    .cur_x     (cur_x_r),
    .cur_y     (cur_y_r),
    .cur_vel   (cur_vel_r),
    .cur_flags (flags_r),
    .cur_box   (box_r),
    .nxt_x     (x_nxt),
    .nxt_y     (y_nxt),
    .nxt_vel   (vel_nxt),
    .nxt_flags (flags_nxt),
    .nxt_box   (box_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cur_vel_r   <= '0;
      flags_r     <= '0;
      box_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cur_x_r     <= x_nxt;
        cur_y_r     <= y_nxt;
        cur_vel_r   <= vel_nxt;
        flags_r     <= flags_nxt;
        box_r       <= box_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold result until transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.new_x     <= x_nxt;
      out_ch.new_y     <= y_nxt;
      out_ch.new_vel_y <= vel_nxt;
      out_ch.hit_flags <= flags_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_ch.new_x == cur_x_r) && (out_ch.new_y == cur_y_r) &&
               (out_ch.new_vel_y == cur_vel_r) && (out_ch.hit_flags == flags_r))
    else $error("result register differs from object state");

  a_start_clears_flags: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.kind == tcr_pkg::KIND_START) |=> (flags_r == '0))
    else $error("start item left flags set");

  a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result stalled");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int POS_W  = 25;
  localparam int VEL_W  = tcr_pkg::VEL_W;
  localparam int EXT_W  = tcr_pkg::EXT_W;
  localparam int TILE_W = tcr_pkg::TILE_W;
  localparam int ATTR_W = tcr_pkg::ATTR_W;
  localparam int FLAG_W = tcr_pkg::FLAG_W;
  localparam longint TILE_SPAN = longint'(1) << tcr_pkg::TILE_SHIFT;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic [2:0] SLOPE_F = 3'd5;
  // per slope kind A..H: line falls with x / offset subtracted
  localparam logic [7:0] SLOPE_FALLS = 8'b1100_0011;
  localparam logic [7:0] SLOPE_SUBS  = 8'b1001_0110;
  localparam logic [ATTR_W-1:0] ATTR_NONE = 8'hFF;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef struct {
    logic                     kind;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [VEL_W-1:0]  vel_y;
    logic [EXT_W-1:0]         half_width;
    logic [EXT_W-1:0]         extent_top;
    logic [EXT_W-1:0]         extent_bottom;
    logic                     skip_npc;
    logic signed [TILE_W-1:0] tile_col;
    logic signed [TILE_W-1:0] tile_row;
    logic [ATTR_W-1:0]        tile_attr;
  } obj_item_t;

  typedef struct {
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic signed [VEL_W-1:0] new_vel_y;
    logic [FLAG_W-1:0]       hit_flags;
  } pose_t;

  class pose_scoreboard;
    longint cx = 0;
    longint cy = 0;
    longint vy = 0;
    longint hw = 0;
    longint tp = 0;
    longint bt = 0;
    logic [FLAG_W-1:0] flg = '0;
    logic ign = 1'b0;
    pose_t pending_poses[$];
    int errors = 0;

    function longint wrap_pos(longint v);
      logic signed [POS_W-1:0] w;
      w = v[POS_W-1:0];
      return w;
    endfunction

    function void push_block(longint tx, longint ty);
      logic [FLAG_W-1:0] hit;
      hit = '0;
      if (cy - tp < ty + tcr_pkg::BLOCK_REACH && cy + bt > ty - tcr_pkg::BLOCK_REACH &&
          cx - hw < tx + tcr_pkg::HALF_TILE && cx - hw > tx) begin
        cx = wrap_pos(tx + tcr_pkg::HALF_TILE + hw);
        hit |= tcr_pkg::FLG_LEFT;
      end
      if (cy - tp < ty + tcr_pkg::BLOCK_REACH && cy + bt > ty - tcr_pkg::BLOCK_REACH &&
          cx + hw > tx - tcr_pkg::HALF_TILE && cx + hw < tx) begin
        cx = wrap_pos(tx - tcr_pkg::HALF_TILE - hw);
        hit |= tcr_pkg::FLG_RIGHT;
      end
      if (cx - hw < tx + tcr_pkg::BLOCK_REACH && cx + hw > tx - tcr_pkg::BLOCK_REACH &&
          cy - tp < ty + tcr_pkg::HALF_TILE && cy - tp > ty) begin
        cy = wrap_pos(ty + tcr_pkg::HALF_TILE + tp);
        vy = 0;
        hit |= tcr_pkg::FLG_CEIL;
      end
      if (cx - hw < tx + tcr_pkg::BLOCK_REACH && cx + hw > tx - tcr_pkg::BLOCK_REACH &&
          cy + bt > ty - tcr_pkg::HALF_TILE && cy + bt < ty) begin
        cy = wrap_pos(ty - tcr_pkg::HALF_TILE - bt);
        vy = 0;
        hit |= tcr_pkg::FLG_FLOOR;
      end
      flg |= hit;
    endfunction

    function void clip_slope(logic [2:0] k, longint tx, longint ty);
      longint half;
      longint line;
      logic in_x;
      half = (cx - tx) / 2;
      line = ty + (SLOPE_FALLS[k] ? -half : half) +
             (SLOPE_SUBS[k] ? -tcr_pkg::SLOPE_OFS : tcr_pkg::SLOPE_OFS);
      in_x = cx < tx + tcr_pkg::HALF_TILE &&
             ((k == SLOPE_F) ? cx >= tx - tcr_pkg::HALF_TILE : cx > tx - tcr_pkg::HALF_TILE);
      if (!k[2]) begin
        if (in_x && cy - tp < line && cy + bt > ty - tcr_pkg::HALF_TILE) begin
          cy = wrap_pos(line + tp);
          if (vy < 0) vy = 0;
          flg |= tcr_pkg::FLG_CEIL;
        end
      end else begin
        flg |= tcr_pkg::FLG_KIND_E << k[1:0];
        if (in_x && cy + bt > line && cy - tp < ty + tcr_pkg::HALF_TILE) begin
          cy = wrap_pos(line - bt);
          if (vy > 0) vy = 0;
          flg |= k[1] ? tcr_pkg::FLG_SLOPE_GH : tcr_pkg::FLG_SLOPE_EF;
        end
      end
    endfunction

    function void wade(longint tx, longint ty);
      if (cx - hw < tx + tcr_pkg::WATER_REACH && cx + hw > tx - tcr_pkg::WATER_REACH &&
          cy - tp < ty + tcr_pkg::WATER_REACH && cy + bt > ty - tcr_pkg::WATER_REACH)
        flg |= tcr_pkg::FLG_WATER;
    endfunction

    function void note_item(obj_item_t it);
      longint tx;
      longint ty;
      pose_t want;
      if (it.kind == tcr_pkg::KIND_START) begin
        cx = it.pos_x;
        cy = it.pos_y;
        vy = it.vel_y;
        hw = it.half_width;
        tp = it.extent_top;
        bt = it.extent_bottom;
        ign = it.skip_npc;
        flg = '0;
      end else begin
        tx = it.tile_col;
        ty = it.tile_row;
        tx = tx * TILE_SPAN;
        ty = ty * TILE_SPAN;
        unique case (it.tile_attr)
          tcr_pkg::ATTR_NPC_BLK: if (!ign) push_block(tx, ty);
          tcr_pkg::ATTR_BLOCK_A, tcr_pkg::ATTR_BLOCK_B,
          tcr_pkg::ATTR_BLOCK_C, tcr_pkg::ATTR_BLOCK_D: push_block(tx, ty);
          tcr_pkg::ATTR_WATER_A, tcr_pkg::ATTR_WATER_B,
          tcr_pkg::ATTR_WATER_C: wade(tx, ty);
          tcr_pkg::ATTR_BW_A, tcr_pkg::ATTR_BW_B, tcr_pkg::ATTR_BW_C: begin
            push_block(tx, ty);
            wade(tx, ty);
          end
          default: begin
            if (it.tile_attr[7:3] == tcr_pkg::ATTR_SLOPE_GRP) begin
              clip_slope(it.tile_attr[2:0], tx, ty);
            end else if (it.tile_attr[7:3] == tcr_pkg::ATTR_SLOPEW_GRP) begin
              clip_slope(it.tile_attr[2:0], tx, ty);
              wade(tx, ty);
            end else if (it.tile_attr[7:2] == tcr_pkg::ATTR_CUR_GRP) begin
              flg |= tcr_pkg::FLG_CURRENT << it.tile_attr[1:0];
            end else if (it.tile_attr[7:2] == tcr_pkg::ATTR_CURW_GRP) begin
              flg |= tcr_pkg::FLG_WATER | (tcr_pkg::FLG_CURRENT << it.tile_attr[1:0]);
            end
          end
        endcase
      end
      want.new_x = cx[POS_W-1:0];
      want.new_y = cy[POS_W-1:0];
      want.new_vel_y = vy[VEL_W-1:0];
      want.hit_flags = flg;
      pending_poses.push_back(want);
    endfunction

    function void check_pose(pose_t got);
      pose_t want;
      if (pending_poses.size() == 0) begin
        $error("unexpected transfer: new_x %0d new_y %0d", got.new_x, got.new_y);
        errors++;
        return;
      end
      want = pending_poses.pop_front();
      if (got.new_x !== want.new_x) begin
        $error("new_x: expected %0d, got %0d", want.new_x, got.new_x);
        errors++;
      end
      if (got.new_y !== want.new_y) begin
        $error("new_y: expected %0d, got %0d", want.new_y, got.new_y);
        errors++;
      end
      if (got.new_vel_y !== want.new_vel_y) begin
        $error("new_vel_y: expected %0d, got %0d", want.new_vel_y, got.new_vel_y);
        errors++;
      end
      if (got.hit_flags !== want.hit_flags) begin
        $error("hit_flags: expected %h, got %h", want.hit_flags, got.hit_flags);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int unsigned cycle_count = 0;
  logic [ATTR_W-1:0] attr_pool[$];
  pose_scoreboard sb = new;

  tcr_in_if  #(.POS_WIDTH(POS_W)) in_ch ();
  tcr_out_if #(.POS_WIDTH(POS_W)) out_ch ();

  tile_collision_resolver #(.POS_WIDTH(POS_W)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // note inputs before checking results so a same-edge pair stays in order
  always @(posedge clk) begin
    obj_item_t seen;
    pose_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.kind = in_ch.kind;
        seen.pos_x = in_ch.pos_x;
        seen.pos_y = in_ch.pos_y;
        seen.vel_y = in_ch.vel_y;
        seen.half_width = in_ch.half_width;
        seen.extent_top = in_ch.extent_top;
        seen.extent_bottom = in_ch.extent_bottom;
        seen.skip_npc = in_ch.skip_npc_block;
        seen.tile_col = in_ch.tile_col;
        seen.tile_row = in_ch.tile_row;
        seen.tile_attr = in_ch.tile_attr;
        sb.note_item(seen);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.new_x = out_ch.new_x;
        got.new_y = out_ch.new_y;
        got.new_vel_y = out_ch.new_vel_y;
        got.hit_flags = out_ch.hit_flags;
        sb.check_pose(got);
      end
    end
  end

  function automatic obj_item_t make_noise();
    obj_item_t it;
    it.kind = 1'($urandom);
    it.pos_x = POS_W'($urandom);
    it.pos_y = POS_W'($urandom);
    it.vel_y = VEL_W'($urandom);
    it.half_width = EXT_W'($urandom);
    it.extent_top = EXT_W'($urandom);
    it.extent_bottom = EXT_W'($urandom);
    it.skip_npc = 1'($urandom);
    it.tile_col = TILE_W'($urandom);
    it.tile_row = TILE_W'($urandom);
    it.tile_attr = ATTR_W'($urandom);
    return it;
  endfunction

  function automatic obj_item_t make_start(logic signed [POS_W-1:0] x,
                                           logic signed [POS_W-1:0] y,
                                           logic signed [VEL_W-1:0] v,
                                           logic [EXT_W-1:0] w, logic [EXT_W-1:0] t,
                                           logic [EXT_W-1:0] b, logic skip);
    obj_item_t it;
    it = make_noise();
    it.kind = tcr_pkg::KIND_START;
    it.pos_x = x;
    it.pos_y = y;
    it.vel_y = v;
    it.half_width = w;
    it.extent_top = t;
    it.extent_bottom = b;
    it.skip_npc = skip;
    return it;
  endfunction

  function automatic obj_item_t make_tile(int col, int row, logic [ATTR_W-1:0] attr);
    obj_item_t it;
    it = make_noise();
    it.kind = tcr_pkg::KIND_TILE;
    it.tile_col = TILE_W'(col);
    it.tile_row = TILE_W'(row);
    it.tile_attr = attr;
    return it;
  endfunction

  function automatic logic [EXT_W-1:0] pick_extent();
    unique case ($urandom_range(0, 9))
      0:       return EXT_W'($urandom);
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return EXT_W'($urandom_range(0, 'h1800));
    endcase
  endfunction

  task automatic put_item(obj_item_t it);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= it.kind;
    in_ch.pos_x <= it.pos_x;
    in_ch.pos_y <= it.pos_y;
    in_ch.vel_y <= it.vel_y;
    in_ch.half_width <= it.half_width;
    in_ch.extent_top <= it.extent_top;
    in_ch.extent_bottom <= it.extent_bottom;
    in_ch.skip_npc_block <= it.skip_npc;
    in_ch.tile_col <= it.tile_col;
    in_ch.tile_row <= it.tile_row;
    in_ch.tile_attr <= it.tile_attr;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic run_directed();
    obj_item_t seq[$];
    seq.push_back(make_tile(0, 0, tcr_pkg::ATTR_BLOCK_A));
    seq.push_back(make_tile(0, 0, {tcr_pkg::ATTR_CURW_GRP, 2'd3}));
    seq.push_back(make_start(POS_MAX, POS_MIN, VEL_MIN, '1, '1, '0, 1'b0));
    seq.push_back(make_tile(1023, -1024, tcr_pkg::ATTR_BLOCK_B));
    seq.push_back(make_start(POS_MIN, POS_MAX, VEL_MAX, '0, '0, '1, 1'b1));
    seq.push_back(make_tile(-1024, 1023, tcr_pkg::ATTR_NPC_BLK));
    seq.push_back(make_start('h1200, 0, 'h100, 'h400, 'h400, 'h400, 1'b0));
    seq.push_back(make_tile(0, 0, tcr_pkg::ATTR_BLOCK_C));
    seq.push_back(make_tile(0, 0, tcr_pkg::ATTR_NPC_BLK));
    // slope F taken exactly on its inclusive left edge
    seq.push_back(make_start('h1000, 'h80, 'h200, 'h100, 'h100, 'h100, 1'b0));
    seq.push_back(make_tile(1, 0, {tcr_pkg::ATTR_SLOPE_GRP, SLOPE_F}));
    // odd negative offset from the tile centre: halving truncates toward zero
    seq.push_back(make_start('h1FFF, 0, -'sh300, 'h200, 'h300, 'h300, 1'b0));
    for (int k = 0; k < 8; k++)
      seq.push_back(make_tile(1, 0, {tcr_pkg::ATTR_SLOPE_GRP, 3'(k)}));
    seq.push_back(make_tile(1, 0, tcr_pkg::ATTR_WATER_A));
    seq.push_back(make_tile(1, 0, tcr_pkg::ATTR_BW_B));
    seq.push_back(make_tile(1, 0, {tcr_pkg::ATTR_SLOPEW_GRP, SLOPE_F}));
    seq.push_back(make_tile(1, 0, {tcr_pkg::ATTR_CUR_GRP, 2'd2}));
    seq.push_back(make_tile(1, 0, ATTR_NONE));
    foreach (seq[i]) put_item(seq[i]);
  endtask

  task automatic run_scenes(int n_items);
    obj_item_t it;
    int sent;
    int col;
    int row;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        it = make_noise();
        put_item(it);
        sent++;
      end else begin
        col = int'($urandom_range(0, 2047)) - 1024;
        row = int'($urandom_range(0, 2047)) - 1024;
        put_item(make_start(POS_W'(col * 'h2000 + int'($urandom_range(0, 'h1FFF))),
                            POS_W'(row * 'h2000 + int'($urandom_range(0, 'h1FFF))),
                            VEL_W'($urandom), pick_extent(), pick_extent(),
                            pick_extent(), 1'($urandom)));
        sent++;
        repeat ($urandom_range(2, 10)) begin
          col = int'(sb.cx >>> tcr_pkg::TILE_SHIFT) + int'($urandom_range(0, 4)) - 2;
          row = int'(sb.cy >>> tcr_pkg::TILE_SHIFT) + int'($urandom_range(0, 4)) - 2;
          if ($urandom_range(0, 7) == 0)
            put_item(make_tile(col, row, ATTR_W'($urandom)));
          else
            put_item(make_tile(col, row, attr_pool[$urandom_range(0, attr_pool.size() - 1)]));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab = '{0, 45, 0, 13};
    stall_tab = '{0, 0, 45, 13};
    rst_n = 1'b0;
    out_ch.ready = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = tcr_pkg::KIND_START;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.vel_y = '0;
    in_ch.half_width = '0;
    in_ch.extent_top = '0;
    in_ch.extent_bottom = '0;
    in_ch.skip_npc_block = 1'b0;
    in_ch.tile_col = '0;
    in_ch.tile_row = '0;
    in_ch.tile_attr = '0;

    attr_pool = '{tcr_pkg::ATTR_WATER_A, tcr_pkg::ATTR_BLOCK_A, tcr_pkg::ATTR_BW_A,
                  tcr_pkg::ATTR_BLOCK_B, tcr_pkg::ATTR_BLOCK_C, tcr_pkg::ATTR_BLOCK_D,
                  tcr_pkg::ATTR_NPC_BLK, tcr_pkg::ATTR_NPC_BLK, tcr_pkg::ATTR_WATER_B,
                  tcr_pkg::ATTR_BW_B, tcr_pkg::ATTR_WATER_C, tcr_pkg::ATTR_BW_C, ATTR_NONE};
    for (int k = 0; k < 8; k++) begin
      attr_pool.push_back({tcr_pkg::ATTR_SLOPE_GRP, 3'(k)});
      attr_pool.push_back({tcr_pkg::ATTR_SLOPE_GRP, 3'(k)});
      attr_pool.push_back({tcr_pkg::ATTR_SLOPEW_GRP, 3'(k)});
    end
    for (int k = 0; k < 4; k++) begin
      attr_pool.push_back({tcr_pkg::ATTR_CUR_GRP, 2'(k)});
      attr_pool.push_back({tcr_pkg::ATTR_CURW_GRP, 2'(k)});
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < 4; p++) begin
      in_idle_pct = idle_tab[p];
      out_stall_pct = stall_tab[p];
      if (p == 0) run_directed();
      run_scenes(RANDOM_ITEMS / 4);
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_poses.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
